// File: design/wavp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_pkg
// Shared types and constants of the wave header parser and pcm unpacker.
// ----------------------------------------------------------------------------
package wavp_pkg;

   // default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // chunk tags, little-endian as assembled from the byte stream
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   // result kinds
   localparam logic [1:0] KIND_REPORT = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [2:0] ERR_BAD_RIFF  = 3'd0;
   localparam logic [2:0] ERR_BAD_WAVE  = 3'd1;
   localparam logic [2:0] ERR_BAD_FMT   = 3'd2;
   localparam logic [2:0] ERR_NO_FMT    = 3'd3;
   localparam logic [2:0] ERR_NO_DATA   = 3'd4;
   localparam logic [2:0] ERR_TRUNCATED = 3'd5;

   // encodings
   localparam logic [15:0] ENC_PCM   = 16'd1;
   localparam logic [15:0] ENC_FLOAT = 16'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] rate_hz;
      logic [15:0] channel_count;
      logic [15:0] out_bits;
      logic        float_fmt;
      logic [31:0] frame_total;
      logic [2:0]  error_code;
      logic        last;
   } rsp_type;

   // command from front to back
   typedef enum logic [1:0] {
      CMD_REPORT = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_ERROR  = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  data_byte;
      logic [2:0]  error_code;
      logic        last;
      logic [31:0] rate_hz;
      logic [15:0] channel_count;
      logic [15:0] out_bits;
      logic        float_fmt;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } entry_type;

   // up to two commands written per byte, in order
   typedef struct packed {
      logic [1:0] count;
      entry_type  first;
      entry_type  second;
   } push_type;

endpackage

`default_nettype wire

// File: design/wavp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_front
// Byte parser: walks the riff chunks, decodes fmt, and turns every byte into
// at most two commands for the back end.
// ----------------------------------------------------------------------------
module wavp_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 take,
   input  wavp_pkg::req_type   req,
   output wavp_pkg::push_type  push
);
   import wavp_pkg::*;

   typedef enum logic [12:0] {
      PH_RIFF     = 13'b0000000000001,
      PH_RSIZE    = 13'b0000000000010,
      PH_WAVE     = 13'b0000000000100,
      PH_CID      = 13'b0000000001000,
      PH_SZ_OTHER = 13'b0000000010000,
      PH_SZ_FMT   = 13'b0000000100000,
      PH_SZ_DATA  = 13'b0000001000000,
      PH_FMT      = 13'b0000010000000,
      PH_SKIP     = 13'b0000100000000,
      PH_DATA     = 13'b0001000000000,
      PH_DROP     = 13'b0010000000000,
      PH_DONE     = 13'b0100000000000,
      PH_HALT     = 13'b1000000000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  field_pos_ff, field_pos_in;
   logic [31:0] shift_ff, shift_in;
   logic [32:0] chunk_left_ff, chunk_left_in;
   logic        format_ok_ff, format_ok_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] chan_ff, chan_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] enc_ff, enc_in;
   logic [31:0] data_left_ff, data_left_in;
   logic [17:0] frame_pos_ff, frame_pos_in;
   logic [1:0]  sample_pos_ff, sample_pos_in;

   // bytes per 24-bit frame and bytes per source frame
   logic [17:0] frame24;
   logic [28:0] bpf;
   assign frame24 = {1'b0, chan_ff, 1'b0} + {2'b00, chan_ff};
   assign bpf     = {13'd0, chan_ff} * {16'd0, bits_ff[15:3]};

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_RIFF;
         field_pos_ff  <= '0;
         shift_ff      <= '0;
         chunk_left_ff <= '0;
         format_ok_ff  <= 1'b0;
         rate_ff       <= '0;
         chan_ff       <= '0;
         bits_ff       <= '0;
         enc_ff        <= '0;
         data_left_ff  <= '0;
         frame_pos_ff  <= '0;
         sample_pos_ff <= '0;
      end else if (take) begin
         phase_ff      <= phase_in;
         field_pos_ff  <= field_pos_in;
         shift_ff      <= shift_in;
         chunk_left_ff <= chunk_left_in;
         format_ok_ff  <= format_ok_in;
         rate_ff       <= rate_in;
         chan_ff       <= chan_in;
         bits_ff       <= bits_in;
         enc_ff        <= enc_in;
         data_left_ff  <= data_left_in;
         frame_pos_ff  <= frame_pos_in;
         sample_pos_ff <= sample_pos_in;
      end
   end

   // next state and commands for one byte
   always_comb begin
      logic [31:0] w;
      logic [15:0] bits_new;
      logic [31:0] dl_new;
      logic [17:0] fp_new;
      logic        rep_v, s0_v, s1_v, err_v;
      logic [2:0]  err_code;
      entry_type   rep_e, s0_e, s1_e, err_e;
      entry_type   cand [4];
      logic [3:0]  cand_v;
      logic [1:0]  n;
      logic        end_old, end_new;

      phase_in      = phase_ff;
      field_pos_in  = field_pos_ff;
      shift_in      = shift_ff;
      chunk_left_in = chunk_left_ff;
      format_ok_in  = format_ok_ff;
      rate_in       = rate_ff;
      chan_in       = chan_ff;
      bits_in       = bits_ff;
      enc_in        = enc_ff;
      data_left_in  = data_left_ff;
      frame_pos_in  = frame_pos_ff;
      sample_pos_in = sample_pos_ff;
      rep_v = 1'b0; s0_v = 1'b0; s1_v = 1'b0; err_v = 1'b0;
      err_code = ERR_BAD_RIFF;
      w        = {req.in_byte, shift_ff[31:8]};
      bits_new = {req.in_byte, bits_ff[7:0]};
      dl_new   = data_left_ff - 32'd1;
      fp_new   = frame_pos_ff + 18'd1;

      unique case (phase_ff)
         PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_SZ_OTHER, PH_SZ_FMT, PH_SZ_DATA: begin
            shift_in     = w;
            field_pos_in = field_pos_ff + 4'd1;
            if (field_pos_ff[1:0] == 2'd3) begin
               field_pos_in = '0;
               unique case (phase_ff)
                  PH_RIFF: begin
                     if (w == TAG_RIFF) begin
                        phase_in = PH_RSIZE;
                     end else begin
                        err_v = 1'b1; err_code = ERR_BAD_RIFF; phase_in = PH_HALT;
                     end
                  end
                  PH_RSIZE: phase_in = PH_WAVE;
                  PH_WAVE: begin
                     if (w == TAG_WAVE) begin
                        phase_in = PH_CID;
                     end else begin
                        err_v = 1'b1; err_code = ERR_BAD_WAVE; phase_in = PH_HALT;
                     end
                  end
                  PH_CID: begin
                     if (w == TAG_FMT) phase_in = PH_SZ_FMT;
                     else if (w == TAG_DATA) phase_in = PH_SZ_DATA;
                     else phase_in = PH_SZ_OTHER;
                  end
                  PH_SZ_DATA: begin
                     if (!format_ok_ff) begin
                        err_v = 1'b1; err_code = ERR_NO_FMT; phase_in = PH_HALT;
                     end else begin
                        rep_v         = 1'b1;
                        data_left_in  = w;
                        frame_pos_in  = '0;
                        sample_pos_in = '0;
                        if (bits_ff == 16'd24 && w < {14'd0, frame24})
                           phase_in = (w != 0) ? PH_DROP : PH_DONE;
                        else
                           phase_in = (w != 0) ? PH_DATA : PH_DONE;
                     end
                  end
                  default: begin
                     // size of fmt or other chunk
                     if (phase_ff == PH_SZ_FMT && w[31:4] != 0) begin
                        chunk_left_in = {1'b0, w - 32'd16} + {32'd0, w[0]};
                        phase_in      = PH_FMT;
                     end else begin
                        chunk_left_in = {1'b0, w} + {32'd0, w[0]};
                        phase_in = (chunk_left_in != 0) ? PH_SKIP : PH_CID;
                     end
                  end
               endcase
            end
         end
         PH_FMT: begin
            case (field_pos_ff)
               4'd0:  enc_in  = {8'd0, req.in_byte};
               4'd1:  enc_in  = {req.in_byte, enc_ff[7:0]};
               4'd2:  chan_in = {8'd0, req.in_byte};
               4'd3:  chan_in = {req.in_byte, chan_ff[7:0]};
               4'd4:  rate_in = {rate_ff[31:8], req.in_byte};
               4'd5:  rate_in = {rate_ff[31:16], req.in_byte, rate_ff[7:0]};
               4'd6:  rate_in = {rate_ff[31:24], req.in_byte, rate_ff[15:0]};
               4'd7:  rate_in = {req.in_byte, rate_ff[23:0]};
               4'd14: bits_in = {8'd0, req.in_byte};
               4'd15: bits_in = bits_new;
               default: ;
            endcase
            field_pos_in = field_pos_ff + 4'd1;
            if (field_pos_ff == 4'd15) begin
               if ((enc_ff != ENC_PCM && enc_ff != ENC_FLOAT) ||
                   (enc_ff == ENC_FLOAT && bits_new != 16'd32)) begin
                  err_v = 1'b1; err_code = ERR_BAD_FMT; phase_in = PH_HALT;
               end else begin
                  format_ok_in = (chan_ff != 0) && (rate_ff != 0) && (bits_new != 0) &&
                                 (bits_new[2:0] == 3'd0);
                  phase_in = (chunk_left_ff != 0) ? PH_SKIP : PH_CID;
               end
            end
         end
         PH_SKIP: begin
            if (chunk_left_ff != 0) chunk_left_in = chunk_left_ff - 33'd1;
            if (chunk_left_in == 0) phase_in = PH_CID;
         end
         PH_DATA: begin
            data_left_in = dl_new;
            if (bits_ff != 16'd24) begin
               s1_v = 1'b1;
               if (dl_new == 0) phase_in = PH_DONE;
            end else begin
               s0_v = (sample_pos_ff == 2'd0);
               s1_v = 1'b1;
               sample_pos_in = (sample_pos_ff == 2'd2) ? 2'd0 : sample_pos_ff + 2'd1;
               frame_pos_in  = fp_new;
               if (fp_new >= frame24) begin
                  frame_pos_in = '0;
                  if (dl_new < {14'd0, frame24}) phase_in = (dl_new != 0) ? PH_DROP : PH_DONE;
               end
            end
         end
         PH_DROP: begin
            if (data_left_ff != 0) data_left_in = dl_new;
            if (data_left_in == 0) phase_in = PH_DONE;
         end
         PH_DONE, PH_HALT: ;
         default: ;
      endcase

      end_old = (phase_ff == PH_DROP) || (phase_ff == PH_DONE) || (phase_ff == PH_HALT);
      end_new = (phase_in == PH_DROP) || (phase_in == PH_DONE) || (phase_in == PH_HALT);

      // end of file: error by where the walk stands
      if (req.is_final) begin
         unique case (phase_in)
            PH_RIFF, PH_RSIZE: begin err_v = 1'b1; err_code = ERR_BAD_RIFF; end
            PH_WAVE: begin err_v = 1'b1; err_code = ERR_BAD_WAVE; end
            PH_CID, PH_SZ_OTHER, PH_SZ_FMT, PH_SZ_DATA, PH_FMT, PH_SKIP: begin
               err_v = 1'b1; err_code = ERR_NO_DATA;
            end
            PH_DATA: begin
               err_v = 1'b1; err_code = ERR_TRUNCATED;
               if (phase_ff == PH_DATA) begin s0_v = 1'b0; s1_v = 1'b0; end
            end
            default: ;
         endcase
      end

      // build commands
      rep_e = '0;
      rep_e.cmd           = CMD_REPORT;
      rep_e.rate_hz       = rate_ff;
      rep_e.channel_count = chan_ff;
      rep_e.out_bits      = (bits_ff == 16'd24) ? 16'd32 : bits_ff;
      rep_e.float_fmt     = (enc_ff == ENC_FLOAT);
      rep_e.dividend      = w;
      rep_e.divisor       = {3'd0, bpf};
      s0_e = '0;
      s0_e.cmd = CMD_SAMPLE;
      s1_e = '0;
      s1_e.cmd       = CMD_SAMPLE;
      s1_e.data_byte = req.in_byte;
      err_e = '0;
      err_e.cmd        = CMD_ERROR;
      err_e.error_code = err_code;

      cand[0] = rep_e; cand[1] = s0_e; cand[2] = s1_e; cand[3] = err_e;
      cand_v  = {err_v, s1_v, s0_v, rep_v};

      // pack the valid ones in order into two slots
      push = '0;
      n = 2'd0;
      for (int i = 0; i < 4; i++) begin
         if (cand_v[i]) begin
            if (n == 2'd0) push.first = cand[i];
            else push.second = cand[i];
            n = n + 2'd1;
         end
      end
      push.count = take ? n : 2'd0;

      // last marking on the final command of the stream
      if (req.is_final || (end_new && !end_old)) begin
         if (n == 2'd2) push.second.last = 1'b1;
         else if (n == 2'd1) push.first.last = 1'b1;
      end

      // end of file returns everything to reset
      if (req.is_final) begin
         phase_in      = PH_RIFF;
         field_pos_in  = '0;
         shift_in      = '0;
         chunk_left_in = '0;
         format_ok_in  = 1'b0;
         rate_in       = '0;
         chan_in       = '0;
         bits_in       = '0;
         enc_in        = '0;
         data_left_in  = '0;
         frame_pos_in  = '0;
         sample_pos_in = '0;
      end
   end

endmodule

`default_nettype wire

// File: design/wavp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_queue
// Short command queue between front and back; takes up to two entries per
// cycle and gives one.
// ----------------------------------------------------------------------------
module wavp_queue #(
   parameter int DEPTH = wavp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wavp_pkg::push_type  push,
   output logic                full,
   output logic                head_valid,
   output wavp_pkg::entry_type head,
   input  wire                 pop
);
   import wavp_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_AT = CW'(DEPTH - 1);

   entry_type       mem [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   wr_next;

   assign wr_next    = wr_ff + AW'(1);
   assign full       = (count_ff >= FULL_AT);
   assign head_valid = (count_ff != 0);
   assign head       = mem[rd_ff];

   // pointers and count
   always_comb begin
      wr_in    = wr_ff + AW'(push.count);
      rd_in    = rd_ff + AW'(pop);
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem[wr_ff] <= push.first;
      if (push.count == 2'd2) mem[wr_next] <= push.second;
   end

endmodule

`default_nettype wire

// File: design/wavp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavp_back
// Executes queued commands: runs the frame count division for the format
// report and drives the result register.
// ----------------------------------------------------------------------------
module wavp_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 head_valid,
   input  wavp_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output wavp_pkg::rsp_type   rsp_data
);
   import wavp_pkg::*;

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // command execution and restoring divider, one quotient bit per cycle
   always_comb begin
      logic        out_free;
      logic [32:0] trial;
      logic [32:0] diff;

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      busy_in      = busy_ff;
      done_in      = done_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      pop          = 1'b0;
      out_free     = !out_valid_ff || rsp_pop;
      trial        = {rem_ff[31:0], quo_ff[31]};
      diff         = trial - {1'b0, head.divisor};

      if (rsp_pop) out_valid_in = 1'b0;

      if (head_valid) begin
         if (head.cmd != CMD_REPORT) begin
            if (out_free) begin
               out_in = '0;
               out_in.kind       = (head.cmd == CMD_SAMPLE) ? KIND_SAMPLE : KIND_ERROR;
               out_in.data_byte  = head.data_byte;
               out_in.error_code = head.error_code;
               out_in.last       = head.last;
               out_valid_in      = 1'b1;
               pop               = 1'b1;
            end
         end else if (done_ff) begin
            if (out_free) begin
               out_in = '0;
               out_in.kind          = KIND_REPORT;
               out_in.rate_hz       = head.rate_hz;
               out_in.channel_count = head.channel_count;
               out_in.out_bits      = head.out_bits;
               out_in.float_fmt     = head.float_fmt;
               out_in.frame_total   = (head.divisor == 0) ? 32'd0 : quo_ff;
               out_in.last          = head.last;
               out_valid_in         = 1'b1;
               pop                  = 1'b1;
               done_in              = 1'b0;
            end
         end else if (!busy_ff) begin
            busy_in = 1'b1;
            step_in = '0;
            rem_in  = '0;
            quo_in  = head.dividend;
         end else begin
            if (!diff[32]) begin
               rem_in = diff;
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         step_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         busy_ff      <= busy_in;
         done_ff      <= done_in;
         step_ff      <= step_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

// File: design/wav_header_parse_and_pcm_unpack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wav_header_parse_and_pcm_unpack
// Parses a riff/wave byte stream and unpacks its pcm data.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle while req_full is low. The parser front
// writes the results of each byte into a short command queue and the back
// end delivers one result per cycle from its output register while rsp_pop
// keeps it drained. The format report at the data chunk waits in the back
// end for the serial frame-count divider (one quotient bit per cycle);
// bytes keep flowing into the queue meanwhile until it fills. A 24-bit
// source yields two results for the first byte of each sample, so it is
// delivered at about 4 results per 3 bytes. Errors end the stream with last
// set; after is_final the block starts over on a new file.
module wav_header_parse_and_pcm_unpack #(
   parameter int QUEUE_DEPTH = wavp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_push,
   output logic               req_full,
   input  wavp_pkg::req_type  req_data,
   output logic               rsp_empty,
   input  wire                rsp_pop,
   output wavp_pkg::rsp_type  rsp_data
);
   import wavp_pkg::*;

   push_type  push;
   entry_type head;
   logic      head_valid;
   logic      head_pop;
   logic      take;

   assign take = req_push && !req_full;

   // parser front
   wavp_front u_front (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .req   (req_data),
      .push  (push)
   );

   // command queue
   wavp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (req_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (head_pop)
   );

   // divider and result register
   wavp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
